>>> rtl/vlpd_pkg.sv
// Shared types and constants for the VarInt length-prefix deframer.
package vlpd_pkg;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_EMPTY    = 2'd1;
  localparam logic [1:0] KIND_TOO_LONG = 2'd2;
  localparam logic [1:0] KIND_NEGATIVE = 2'd3;

  // Prefix coding
  localparam logic [7:0] VALUE_MASK       = 8'h7F;
  localparam logic [7:0] CONT_BIT         = 8'h80;
  localparam int         LENGTH_BITS      = 32;
  localparam logic [2:0] MAX_PREFIX_BYTES = 3'd5;
  localparam logic [4:0] GROUP_BITS       = 5'd7;

  // Default depth of the queue between parser and output stage
  localparam int QUEUE_DEPTH = 2;

  // One result item
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       first;
    logic       last;
  } vlpd_result_t;

endpackage

>>> rtl/varint_length_prefix_deframer_core.sv
// Top level of the VarInt length-prefix deframer.
// Takes one stream byte per cycle while in_ready is high: each byte is either
// part of a little-endian base-128 length prefix or a payload byte, and the
// block emits at most one result per byte (payload byte with first/last marks,
// empty packet, prefix too long, or negative length). Prefix or countdown state
// updates as each byte is taken, so bytes go back to back while the queue has
// room; a result is written to the queue and then to the output register.
// A queue of QDEPTH entries and an output register separate the parser from
// the result channel, so in_ready drops only while the queue is full.
module varint_length_prefix_deframer_core
  import vlpd_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic       out_first_of_packet,
  output logic       out_last_of_packet
);

  logic         accept;
  logic         res_valid;
  vlpd_result_t res;
  logic         q_valid;
  logic         q_pop;
  vlpd_result_t q_data;
  vlpd_result_t out_data;

  assign accept = in_valid && in_ready;

  vlpd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  vlpd_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && res_valid),
    .push_data (res),
    .not_full  (in_ready),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  vlpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_byte            = out_data.data;
  assign out_kind            = out_data.kind;
  assign out_first_of_packet = out_data.first;
  assign out_last_of_packet  = out_data.last;

endmodule

>>> rtl/vlpd_front.sv
// Front end: parses the length prefix, tracks payload bytes, classifies each byte.
module vlpd_front
  import vlpd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         accept,
  input  logic [7:0]   in_byte,
  output logic         res_valid,
  output vlpd_result_t res
);

  logic                   in_payload_r, in_payload_nxt;
  logic [LENGTH_BITS-1:0] accum_r, accum_nxt;
  logic [2:0]             pcount_r, pcount_nxt;
  logic [LENGTH_BITS-2:0] remain_r, remain_nxt;
  logic                   first_r, first_nxt;

  logic [4:0]             shift_amt;
  logic [LENGTH_BITS-1:0] accum_or;
  logic [2:0]             pcount_inc;
  logic                   last_byte;

  // Merge the next seven value bits at their group position
  assign shift_amt  = 5'(pcount_r) * GROUP_BITS;
  assign accum_or   = accum_r | (LENGTH_BITS'(in_byte & VALUE_MASK) << shift_amt);
  assign pcount_inc = pcount_r + 3'd1;
  assign last_byte  = (remain_r <= (LENGTH_BITS-1)'(1));

  // Classify the byte and work out the next parser state
  always_comb begin
    in_payload_nxt = in_payload_r;
    accum_nxt      = accum_r;
    pcount_nxt     = pcount_r;
    remain_nxt     = remain_r;
    first_nxt      = first_r;
    res_valid      = 1'b0;
    res            = '{data: 8'd0, kind: KIND_PAYLOAD, first: 1'b0, last: 1'b0};

    if (in_payload_r) begin
      res_valid = 1'b1;
      res       = '{data: in_byte, kind: KIND_PAYLOAD, first: first_r, last: last_byte};
      first_nxt = 1'b0;
      if (last_byte) begin
        remain_nxt     = '0;
        in_payload_nxt = 1'b0;
        accum_nxt      = '0;
        pcount_nxt     = '0;
      end else begin
        remain_nxt = remain_r - (LENGTH_BITS-1)'(1);
      end
    end else if ((in_byte & CONT_BIT) != 8'd0) begin
      // Continuation: keep gathering, or drop an overlong prefix
      if (pcount_inc >= MAX_PREFIX_BYTES) begin
        res_valid  = 1'b1;
        res.kind   = KIND_TOO_LONG;
        accum_nxt  = '0;
        pcount_nxt = '0;
      end else begin
        accum_nxt  = accum_or;
        pcount_nxt = pcount_inc;
      end
    end else begin
      // Final prefix byte
      accum_nxt  = '0;
      pcount_nxt = '0;
      if (accum_or[LENGTH_BITS-1]) begin
        res_valid = 1'b1;
        res.kind  = KIND_NEGATIVE;
      end else if (accum_or == '0) begin
        res_valid = 1'b1;
        res.kind  = KIND_EMPTY;
        res.last  = 1'b1;
      end else begin
        remain_nxt     = accum_or[LENGTH_BITS-2:0];
        in_payload_nxt = 1'b1;
        first_nxt      = 1'b1;
      end
    end
  end

  // Advance parser state on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_payload_r <= 1'b0;
      accum_r      <= '0;
      pcount_r     <= '0;
      remain_r     <= '0;
      first_r      <= 1'b0;
    end else if (accept) begin
      in_payload_r <= in_payload_nxt;
      accum_r      <= accum_nxt;
      pcount_r     <= pcount_nxt;
      remain_r     <= remain_nxt;
      first_r      <= first_nxt;
    end
  end

endmodule

>>> rtl/vlpd_queue.sv
// Short result queue between the parser and the output stage.
module vlpd_queue
  import vlpd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  vlpd_result_t push_data,
  output logic         not_full,
  input  logic         pop,
  output logic         not_empty,
  output vlpd_result_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  vlpd_result_t        mem_r [DEPTH];
  logic [PW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]       count_r, count_nxt;

  assign not_full  = (count_r != CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/vlpd_back.sv
// Back end: output register that drains the queue onto the result channel.
module vlpd_back
  import vlpd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  vlpd_result_t q_data,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_ready,
  output vlpd_result_t out_data
);

  logic         out_valid_r, out_valid_nxt;
  vlpd_result_t out_r;
  logic         load;

  // Refill the register when it is empty or its transfer completes
  assign load          = !out_valid_r || out_ready;
  assign q_pop         = load && q_valid;
  assign out_valid_nxt = load ? q_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= q_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/vlpd_checker.sv
// Port-level checker for the deframer, bound to the top level.
module vlpd_checker
  import vlpd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] out_kind,
  input logic       out_first_of_packet,
  input logic       out_last_of_packet
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_kind))
    else $error("result changed while stalled");

  // Non-payload results carry a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_PAYLOAD |-> out_byte == 8'd0)
    else $error("non-payload result with nonzero byte");

  // Error results carry no packet marks
  a_err_marks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_TOO_LONG || out_kind == KIND_NEGATIVE)
      |-> !out_first_of_packet && !out_last_of_packet)
    else $error("error result with packet marks");

  // Empty packet closes without opening
  a_empty_marks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_EMPTY |-> out_last_of_packet && !out_first_of_packet)
    else $error("empty packet with wrong marks");

  // Results are never present right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind varint_length_prefix_deframer_core vlpd_checker u_vlpd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_byte            (out_byte),
  .out_kind            (out_kind),
  .out_first_of_packet (out_first_of_packet),
  .out_last_of_packet  (out_last_of_packet)
);

>>> tb/sv/tb_varint_length_prefix_deframer_core.sv
// Self-checking testbench for the VarInt length-prefix deframer core.
module tb_varint_length_prefix_deframer_core;
  import vlpd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       out_first_of_packet;
  logic       out_last_of_packet;

  // Stream bytes waiting to be driven, and results still owed by the block
  logic [7:0]   stream_q[$];
  vlpd_result_t pending_results[$];
  bit           byte_busy;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           hold_left;
  int           errors;
  int           cycles;

  // Deframer state as the block should hold it
  bit          st_in_payload;
  logic [31:0] st_accum;
  logic [2:0]  st_count;
  logic [30:0] st_remaining;
  bit          st_first_byte;

  varint_length_prefix_deframer_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_byte             (in_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_byte            (out_byte),
    .out_kind            (out_kind),
    .out_first_of_packet (out_first_of_packet),
    .out_last_of_packet  (out_last_of_packet)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the deframer state by one stream byte; return the result it causes
  function automatic void deframe_byte(input logic [7:0] b, output bit has_res,
                                       output vlpd_result_t res);
    logic [4:0]  shift;
    bit          is_last;
    has_res = 1'b0;
    res = '0;
    if (st_in_payload) begin
      is_last = (st_remaining <= 31'd1);
      res.data = b;
      res.kind = KIND_PAYLOAD;
      res.first = st_first_byte;
      res.last = is_last;
      has_res = 1'b1;
      st_first_byte = 1'b0;
      if (is_last) begin
        st_remaining = '0;
        st_in_payload = 1'b0;
        st_accum = '0;
        st_count = '0;
      end else begin
        st_remaining = st_remaining - 31'd1;
      end
      return;
    end
    // Gather seven value bits; a fifth byte keeps only what fits in 32 bits
    shift = {2'b00, st_count} * 5'd7;
    if (st_count < MAX_PREFIX_BYTES)
      st_accum = st_accum | ({24'd0, b & VALUE_MASK} << shift);
    st_count = st_count + 3'd1;
    if ((b & CONT_BIT) != 8'd0) begin
      if (st_count >= MAX_PREFIX_BYTES) begin
        st_accum = '0;
        st_count = '0;
        res.kind = KIND_TOO_LONG;
        has_res = 1'b1;
      end
      return;
    end
    if (st_accum[31]) begin
      res.kind = KIND_NEGATIVE;
      has_res = 1'b1;
    end else if (st_accum == 32'd0) begin
      res.kind = KIND_EMPTY;
      res.last = 1'b1;
      has_res = 1'b1;
    end else begin
      st_remaining = st_accum[30:0];
      st_in_payload = 1'b1;
      st_first_byte = 1'b1;
    end
    st_accum = '0;
    st_count = '0;
  endfunction

  // Drive queued stream bytes at the falling edge, record each transfer at the rising edge
  initial begin
    vlpd_result_t res;
    bit           has_res;
    in_valid = 1'b0;
    in_byte = 8'd0;
    byte_busy = 1'b0;
    forever begin
      @(negedge clk);
      if (!byte_busy) begin
        if (stream_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_byte <= stream_q.pop_front();
          in_valid <= 1'b1;
          byte_busy = 1'b1;
        end else begin
          in_valid <= 1'b0;
          in_byte <= 8'($urandom);
        end
      end
      @(posedge clk);
      if (byte_busy && in_ready) begin
        deframe_byte(in_byte, has_res, res);
        if (has_res)
          pending_results.push_back(res);
        byte_busy = 1'b0;
      end
    end
  end

  // Stall the result channel at random, or hold it off for a counted stretch
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Compare each result transfer with the oldest expected result
  initial begin
    vlpd_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: byte %0h kind %0d first %0b last %0b",
                 out_byte, out_kind, out_first_of_packet, out_last_of_packet);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %0h, got %0h", want.data, out_byte);
            errors++;
          end
          if (out_kind !== want.kind) begin
            $error("out_kind: expected %0d, got %0d", want.kind, out_kind);
            errors++;
          end
          if (out_first_of_packet !== want.first) begin
            $error("out_first_of_packet: expected %0b, got %0b",
                   want.first, out_first_of_packet);
            errors++;
          end
          if (out_last_of_packet !== want.last) begin
            $error("out_last_of_packet: expected %0b, got %0b",
                   want.last, out_last_of_packet);
            errors++;
          end
        end
      end
    end
  end

  // Bound the run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("varint_length_prefix_deframer_core: mismatch");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    stream_q.push_back(b);
  endtask

  // Hold off new stimulus until every queued byte is taken and every result is back
  task automatic wait_for_results();
    while (stream_q.size() != 0 || byte_busy || pending_results.size() != 0)
      @(posedge clk);
  endtask

  // Encode a length as a VarInt prefix, optionally padded with zero groups
  task automatic send_prefix(input logic [31:0] len, input int pad);
    int         groups;
    int         total;
    logic [7:0] b;
    groups = 1;
    while (groups < 5 && (len >> (7 * groups)) != 32'd0)
      groups++;
    total = groups + pad;
    if (total > 5)
      total = 5;
    for (int i = 0; i < total; i++) begin
      b = {1'b0, 7'(len >> (7 * i))};
      // fifth byte: upper value bits are dropped, so fill them at random
      if (i == 4)
        b[6:4] = 3'($urandom_range(7));
      if (i < total - 1)
        b[7] = 1'b1;
      send_byte(b);
    end
  endtask

  task automatic send_packet(input int len, input int pad);
    send_prefix(32'(len), pad);
    repeat (len) send_byte(8'($urandom));
  endtask

  task automatic send_too_long();
    repeat (5) send_byte({1'b1, 7'($urandom)});
  endtask

  task automatic send_negative();
    send_prefix({1'b1, 31'($urandom)}, 0);
  endtask

  task automatic test_empty_packet();
    send_byte(8'h00);
  endtask

  task automatic test_short_packets();
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'h80);
  endtask

  task automatic test_padded_prefix();
    send_byte(8'h81);
    send_byte(8'h00);
    send_byte(8'hAA);
  endtask

  task automatic test_dropped_high_bits();
    send_byte(8'h80);
    send_byte(8'h80);
    send_byte(8'h80);
    send_byte(8'h80);
    send_byte(8'h70);
  endtask

  task automatic test_prefix_too_long();
    repeat (5) send_byte(8'hFF);
  endtask

  task automatic test_negative_length();
    send_byte(8'h80);
    send_byte(8'h80);
    send_byte(8'h80);
    send_byte(8'h80);
    send_byte(8'h08);
    wait_for_results();
  endtask

  // Mostly well-formed packets with random content, some broken prefixes
  task automatic test_random_traffic(input int n, input int s_pct, input int r_pct);
    int start;
    int pick;
    int len;
    int pad;
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    start = stream_q.size();
    while (stream_q.size() - start < n) begin
      pick = $urandom_range(99);
      if (pick < 82) begin
        pick = $urandom_range(99);
        if (pick < 5)
          len = $urandom_range(128, 300);
        else if (pick < 20)
          len = $urandom_range(13, 40);
        else
          len = $urandom_range(0, 12);
        pad = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0;
        send_packet(len, pad);
      end else if (pick < 91) begin
        send_too_long();
      end else begin
        send_negative();
      end
    end
    wait_for_results();
  endtask

  // Block the result channel while a long packet is offered, so the input stalls
  task automatic test_receiver_hold();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 300;
    send_packet(60, 0);
    wait_for_results();
  endtask

  // Largest positive length: only the head of the payload is sent
  task automatic test_max_length();
    send_idle_pct = 20;
    recv_stall_pct = 20;
    send_prefix(32'h7FFF_FFFF, 0);
    repeat (20) send_byte(8'($urandom));
    wait_for_results();
  endtask

  initial begin
    errors = 0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    st_in_payload = 1'b0;
    st_accum = '0;
    st_count = '0;
    st_remaining = '0;
    st_first_byte = 1'b0;
    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_packet();
    test_short_packets();
    test_padded_prefix();
    test_dropped_high_bits();
    test_prefix_too_long();
    test_negative_length();
    test_random_traffic(200, 0, 0);
    test_random_traffic(200, 47, 0);
    test_random_traffic(200, 0, 47);
    test_random_traffic(200, 36, 36);
    test_receiver_hold();
    test_max_length();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("varint_length_prefix_deframer_core: match");
    else
      $display("varint_length_prefix_deframer_core: mismatch");
    $finish;
  end

endmodule
